>>> rtl/poly_area_pkg.sv
// Package for the polygon area block: widths and saturation limits.
`timescale 1ns / 1ps
`default_nettype none

package poly_area_pkg;

    // Port widths of the vertex and result channels, and the ring accumulator width
    localparam int COORD_W = 24;
    localparam int RING_W  = 61;
    localparam int GEOM_W  = 63;

    // Default for the significant coordinate bits
    localparam int COORD_BITS_DEF = 24;

    // Saturation limits of the ring and geometry accumulators
    localparam logic [RING_W-1:0] RING_MAX = {1'b0, {(RING_W-1){1'b1}}};
    localparam logic [RING_W-1:0] RING_MIN = {1'b1, {(RING_W-1){1'b0}}};
    localparam logic [GEOM_W-1:0] GEOM_MAX = {1'b0, {(GEOM_W-1){1'b1}}};
    localparam logic [GEOM_W-1:0] GEOM_MIN = {1'b1, {(GEOM_W-1){1'b0}}};

    // Largest ring magnitude: |RING_MIN|
    localparam logic [RING_W-1:0] RING_MAG_MAX = {1'b1, {(RING_W-1){1'b0}}};

endpackage

`default_nettype wire

>>> rtl/polygon_area_with_holes_top.sv
// Top level: streaming doubled shoelace area of polygons with holes.
// m_valid rises when a geometry's last vertex moves from stage 4 into the output register.
// Throughput: one vertex per cycle; a held result does not stop intake until the 4-stage pipe fills.
// Stages: input register, four products, ring accumulate, ring close/abs, geometry accumulate.
// Reset (aresetn low, synchronous): pipe empty, accumulators zero, next vertex opens a new ring.
`timescale 1ns / 1ps
`default_nettype none

module polygon_area_with_holes_top #(
    parameter int COORD_BITS = poly_area_pkg::COORD_BITS_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // vertex channel
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire  [poly_area_pkg::COORD_W-1:0]     s_x_coord,
    input  wire  [poly_area_pkg::COORD_W-1:0]     s_y_coord,
    input  wire                                   s_ring_is_hole,
    input  wire                                   s_ring_end,
    input  wire                                   s_geometry_end,
    // result channel
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [poly_area_pkg::GEOM_W-1:0]      m_doubled_area,
    output logic                                  m_area_saturated
);

    localparam int IN_W = poly_area_pkg::COORD_W;
    localparam int CW   = COORD_BITS;      // significant coordinate bits
    localparam int PW   = 2 * CW;          // one product
    localparam int TW   = PW + 1;          // difference of two products
    localparam int RW   = poly_area_pkg::RING_W;
    localparam int GW   = poly_area_pkg::GEOM_W;

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage moves when the next one is empty
    // or moving, so bubbles close up while a result waits on m_ready.
    // Only a vertex that ends both its ring and its geometry needs the output register.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic out_free, s4_emit, s4_go, s4_free, s3_go, s3_free, s2_go, s2_free;
    logic s1_go, s1_free, accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s4_go    = v4_reg && (!s4_emit || out_free);
    assign s4_free  = !v4_reg || s4_go;
    assign s3_go    = v3_reg && s4_free;
    assign s3_free  = !v3_reg || s3_go;
    assign s2_go    = v2_reg && s3_free;
    assign s2_free  = !v2_reg || s2_go;
    assign s1_go    = v1_reg && s2_free;
    assign s1_free  = !v1_reg || s1_go;
    assign s_ready  = s1_free;
    assign accept   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Coordinate extension: keep the low COORD_BITS bits, signed.
    // With more bits than the port, the port value is taken unsigned.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] x_in, y_in;

    generate
        if (CW <= IN_W) begin : g_coord_trunc
            assign x_in = s_x_coord[CW-1:0];
            assign y_in = s_y_coord[CW-1:0];
        end else begin : g_coord_zext
            assign x_in = {{(CW-IN_W){1'b0}}, s_x_coord};
            assign y_in = {{(CW-IN_W){1'b0}}, s_y_coord};
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage 1: vertex register plus ring tracking (first and previous
    // vertex, hole flag latched at the ring's first vertex).
    // ------------------------------------------------------------------
    logic signed [CW-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic                 at_start_reg, hole_reg;
    logic signed [CW-1:0] first_x_next, first_y_next;
    logic                 hole_next;

    logic signed [CW-1:0] x1_reg, y1_reg, px1_reg, py1_reg, fx1_reg, fy1_reg;
    logic                 start1_reg, hole1_reg, rend1_reg, gend1_reg;

    always_comb begin
        first_x_next = at_start_reg ? x_in : first_x_reg;
        first_y_next = at_start_reg ? y_in : first_y_reg;
        hole_next    = at_start_reg ? s_ring_is_hole : hole_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_x_reg  <= '0;
            first_y_reg  <= '0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            hole_reg     <= 1'b0;
            at_start_reg <= 1'b1;
        end else if (accept) begin
            first_x_reg  <= first_x_next;
            first_y_reg  <= first_y_next;
            prev_x_reg   <= x_in;
            prev_y_reg   <= y_in;
            hole_reg     <= hole_next;
            at_start_reg <= s_ring_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x1_reg     <= x_in;
            y1_reg     <= y_in;
            px1_reg    <= prev_x_reg;
            py1_reg    <= prev_y_reg;
            fx1_reg    <= first_x_next;
            fy1_reg    <= first_y_next;
            start1_reg <= at_start_reg;
            hole1_reg  <= hole_next;
            rend1_reg  <= s_ring_end;
            gend1_reg  <= s_geometry_end;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the four cross products. The edge from the previous vertex
    // and the closing edge back to the first vertex are both formed here;
    // the closing edge is only used on a ring's last vertex.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] pa_next, pb_next, pc_next, pd_next;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic                 start2_reg, hole2_reg, rend2_reg, gend2_reg;

    assign pa_next = px1_reg * y1_reg;
    assign pb_next = x1_reg * py1_reg;
    assign pc_next = x1_reg * fy1_reg;
    assign pd_next = fx1_reg * y1_reg;

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            pc_reg     <= pc_next;
            pd_reg     <= pd_next;
            start2_reg <= start1_reg;
            hole2_reg  <= hole1_reg;
            rend2_reg  <= rend1_reg;
            gend2_reg  <= gend1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: running ring sum, saturating at 61 bits. The first vertex
    // of a ring restarts it at zero.
    // ------------------------------------------------------------------
    logic signed [TW-1:0] t1, t2_next;
    logic        [RW:0]   rsum_wide;
    logic                 rsum_ovf;
    logic        [RW-1:0] ring_sum_reg, ring_sum_next;

    logic        [RW-1:0] r1_reg;
    logic signed [TW-1:0] t2_reg;
    logic                 clip3_reg, hole3_reg, rend3_reg, gend3_reg;

    always_comb begin
        t1        = {pa_reg[PW-1], pa_reg} - {pb_reg[PW-1], pb_reg};
        t2_next   = {pc_reg[PW-1], pc_reg} - {pd_reg[PW-1], pd_reg};
        rsum_wide = {ring_sum_reg[RW-1], ring_sum_reg} + {{(RW+1-TW){t1[TW-1]}}, t1};
        rsum_ovf  = !start2_reg && (rsum_wide[RW] != rsum_wide[RW-1]);
        if (start2_reg) begin
            ring_sum_next = '0;
        end else if (rsum_ovf) begin
            ring_sum_next = rsum_wide[RW] ? poly_area_pkg::RING_MIN : poly_area_pkg::RING_MAX;
        end else begin
            ring_sum_next = rsum_wide[RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_sum_reg <= '0;
        end else if (s2_go) begin
            ring_sum_reg <= ring_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_go) begin
            r1_reg    <= ring_sum_next;
            t2_reg    <= t2_next;
            clip3_reg <= rsum_ovf;
            hole3_reg <= hole2_reg;
            rend3_reg <= rend2_reg;
            gend3_reg <= gend2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: close the ring against its first vertex, saturate, and
    // take the magnitude (up to 2^60, so unsigned 61 bits).
    // ------------------------------------------------------------------
    logic [RW:0]   close_wide;
    logic          close_ovf;
    logic [RW-1:0] r2, mag_next;

    logic [RW-1:0] mag4_reg;
    logic          clip4_reg, hole4_reg, rend4_reg, gend4_reg;

    always_comb begin
        close_wide = {r1_reg[RW-1], r1_reg} + {{(RW+1-TW){t2_reg[TW-1]}}, t2_reg};
        close_ovf  = rend3_reg && (close_wide[RW] != close_wide[RW-1]);
        if (close_ovf) begin
            r2 = close_wide[RW] ? poly_area_pkg::RING_MIN : poly_area_pkg::RING_MAX;
        end else begin
            r2 = close_wide[RW-1:0];
        end
        mag_next = r2[RW-1] ? (~r2 + 1'b1) : r2;
    end

    always_ff @(posedge aclk) begin
        if (s3_go) begin
            mag4_reg  <= mag_next;
            clip4_reg <= clip3_reg || close_ovf;
            hole4_reg <= hole3_reg;
            rend4_reg <= rend3_reg;
            gend4_reg <= gend3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: geometry total, outer rings add and holes subtract,
    // saturating at 63 bits. A geometry end loads the output register
    // and clears the total and the clip flag.
    // ------------------------------------------------------------------
    logic [GW:0]   gsum_wide;
    logic          gsum_ovf;
    logic [GW-1:0] gsum_sat;
    logic [GW-1:0] geom_reg, geom_next;
    logic          clipped_reg, clipped_next, clipped_acc;
    logic [GW-1:0] area_reg;
    logic          sat_reg;

    assign s4_emit = v4_reg && rend4_reg && gend4_reg;

    always_comb begin
        if (hole4_reg) begin
            gsum_wide = {geom_reg[GW-1], geom_reg} - {{(GW+1-RW){1'b0}}, mag4_reg};
        end else begin
            gsum_wide = {geom_reg[GW-1], geom_reg} + {{(GW+1-RW){1'b0}}, mag4_reg};
        end
        gsum_ovf = rend4_reg && (gsum_wide[GW] != gsum_wide[GW-1]);
        if (gsum_ovf) begin
            gsum_sat = gsum_wide[GW] ? poly_area_pkg::GEOM_MIN : poly_area_pkg::GEOM_MAX;
        end else begin
            gsum_sat = gsum_wide[GW-1:0];
        end
        clipped_acc = clipped_reg || clip4_reg || gsum_ovf;

        geom_next    = geom_reg;
        clipped_next = clipped_reg;
        if (s4_go) begin
            if (s4_emit) begin
                geom_next    = '0;
                clipped_next = 1'b0;
            end else begin
                geom_next    = rend4_reg ? gsum_sat : geom_reg;
                clipped_next = clipped_acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geom_reg    <= '0;
            clipped_reg <= 1'b0;
        end else begin
            geom_reg    <= geom_next;
            clipped_reg <= clipped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_go && s4_emit) begin
            area_reg <= gsum_sat;
            sat_reg  <= clipped_acc;
        end
    end

    // stage valids and the output register's valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s1_free) v1_reg <= accept;
            if (s2_free) v2_reg <= s1_go;
            if (s3_free) v3_reg <= s2_go;
            if (s4_free) v4_reg <= s3_go;
            if (out_free) m_valid_reg <= s4_go && s4_emit;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_doubled_area   = area_reg;
    assign m_area_saturated = sat_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // a ring end at intake always opens a new ring for the next vertex
    a_ring_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_ring_end) |=> at_start_reg)
        else $error("next vertex does not open a new ring");

    // emitting a result leaves a clean geometry total behind
    a_geom_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s4_go && s4_emit) |=> (geom_reg == '0) && !clipped_reg)
        else $error("geometry total not cleared after a result");

    // a result-bearing vertex never leaves stage 4 into a held output
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (s4_emit && m_valid_reg && !m_ready) |=> v4_reg && m_valid_reg)
        else $error("result lost while the output was held");

    // ring magnitude stays within the saturated ring range
    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (mag4_reg <= poly_area_pkg::RING_MAG_MAX))
        else $error("ring magnitude out of range");

endmodule

`default_nettype wire
